// ----- rtl/rgb2bmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_pkg
// shared types and constants of the rgb565 to bmp24 stream converter
// ----------------------------------------------------------------------------
package rgb2bmp_pkg;

  // configuration register fields and port
  localparam int DIM_W             = 13;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int APB_AW            = 3;
  localparam int APB_DW            = 32;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1280;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd720;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // bmp layout
  localparam int HEADER_BYTES   = 54;
  localparam int INFO_BYTES     = 40;
  localparam int BITS_PER_PIXEL = 24;

  // byte positions within the bytes of one pixel
  localparam int POS_W     = 6;
  localparam int POS_BLUE  = HEADER_BYTES;
  localparam int POS_GREEN = HEADER_BYTES + 1;
  localparam int POS_RED   = HEADER_BYTES + 2;

  // pixel queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // effective frame dimensions
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // one classified pixel
  typedef struct packed {
    logic [15:0] pixel;
    logic        header;
    logic        frame_end;
    logic [1:0]  pad;
  } entry_t;

endpackage

// ----- rtl/rgb2bmp_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_pix_if
// pixel channel: valid, ready and one rgb565 word
// ----------------------------------------------------------------------------
interface rgb2bmp_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

// ----- rtl/rgb2bmp_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_byte_if
// byte channel: valid, ready, file byte and its end marks
// ----------------------------------------------------------------------------
interface rgb2bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_last;

  modport source (output valid, output out_byte, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_last,
                output ready);
endinterface

// ----- rtl/rgb2bmp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_cfg
// apb register file for frame width and height, with clamped outputs
// ----------------------------------------------------------------------------
module rgb2bmp_cfg #(
  parameter int MAX_DIMENSION = rgb2bmp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgb2bmp_pkg::APB_AW-1:0] paddr,
  input  logic [rgb2bmp_pkg::APB_DW-1:0] pwdata,
  output logic [rgb2bmp_pkg::APB_DW-1:0] prdata,
  output logic                           pready,
  output rgb2bmp_pkg::dims_t             dims
);
  import rgb2bmp_pkg::*;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  reg_idx_t         idx;
  logic             wr;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign dims.width  = clamp_dim(frame_width);
  assign dims.height = clamp_dim(frame_height);

endmodule

// ----- rtl/rgb2bmp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_front
// accepts pixels, tracks column and row, marks header, row padding and frame ends
// ----------------------------------------------------------------------------
module rgb2bmp_front #(
  parameter int CW = 12
) (
  input  logic                clk,
  input  logic                rst,
  rgb2bmp_pix_if.sink         pix_in,
  input  rgb2bmp_pkg::dims_t  dims,
  output rgb2bmp_pkg::entry_t push_data,
  output logic                push_valid,
  input  logic                push_ready
);
  import rgb2bmp_pkg::*;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic          row_end;
  logic          frame_end;
  logic          xfer;

  assign row_end   = 32'(column_count) >= (32'(dims.width) - 32'd1);
  assign frame_end = row_end && (32'(row_count) >= (32'(dims.height) - 32'd1));
  assign xfer      = pix_in.valid && push_ready;

  assign pix_in.ready        = push_ready;
  assign push_valid          = pix_in.valid;
  assign push_data.pixel     = pix_in.pixel_word;
  assign push_data.header    = (column_count == '0) && (row_count == '0);
  assign push_data.frame_end = frame_end;
  // row padding to a 4-byte stride equals width mod 4
  assign push_data.pad       = row_end ? dims.width[1:0] : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (xfer) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

endmodule

// ----- rtl/rgb2bmp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_queue
// short fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
module rgb2bmp_queue (
  input  logic                clk,
  input  logic                rst,
  input  rgb2bmp_pkg::entry_t push_data,
  input  logic                push_valid,
  output logic                push_ready,
  output rgb2bmp_pkg::entry_t head,
  output logic                head_valid,
  input  logic                pop
);
  import rgb2bmp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          push;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = 32'(fill) != QUEUE_DEPTH;
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   fill <= fill + NW'(1);
        2'b01:   fill <= fill - NW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/rgb2bmp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_back
// byte sequencer: header, pixel bytes and row padding into an output register
// ----------------------------------------------------------------------------
module rgb2bmp_back (
  input  logic                clk,
  input  logic                rst,
  input  rgb2bmp_pkg::dims_t  dims,
  input  rgb2bmp_pkg::entry_t head,
  input  logic                head_valid,
  output logic                pop,
  rgb2bmp_byte_if.source      byte_out
);
  import rgb2bmp_pkg::*;

  logic [14:0]      stride;
  logic [31:0]      data_size;
  logic [31:0]      total_size;
  logic [31:0]      neg_height;
  logic [POS_W-1:0] pos;
  logic             started;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] last_pos;
  logic             is_last;
  logic             load;
  logic [7:0]       next_byte;
  logic [4:0]       r5;
  logic [5:0]       g6;
  logic [4:0]       b5;
  logic             ov;
  logic [7:0]       obyte;
  logic             orl;
  logic             ofl;

  function automatic logic [7:0] le_byte(input logic [31:0] v, input int unsigned k);
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] i,
                                          input logic [31:0] total,
                                          input logic [31:0] wid,
                                          input logic [31:0] nh,
                                          input logic [31:0] dsize);
    logic [7:0] b;
    case (i)
      6'd0:  b = 8'h42;
      6'd1:  b = 8'h4d;
      6'd2:  b = le_byte(total, 0);
      6'd3:  b = le_byte(total, 1);
      6'd4:  b = le_byte(total, 2);
      6'd5:  b = le_byte(total, 3);
      6'd10: b = 8'(HEADER_BYTES);
      6'd14: b = 8'(INFO_BYTES);
      6'd18: b = le_byte(wid, 0);
      6'd19: b = le_byte(wid, 1);
      6'd20: b = le_byte(wid, 2);
      6'd21: b = le_byte(wid, 3);
      6'd22: b = le_byte(nh, 0);
      6'd23: b = le_byte(nh, 1);
      6'd24: b = le_byte(nh, 2);
      6'd25: b = le_byte(nh, 3);
      6'd26: b = 8'd1;
      6'd28: b = 8'(BITS_PER_PIXEL);
      6'd34: b = le_byte(dsize, 0);
      6'd35: b = le_byte(dsize, 1);
      6'd36: b = le_byte(dsize, 2);
      6'd37: b = le_byte(dsize, 3);
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // size fields, recomputed every cycle from the steady configuration
  always_ff @(posedge clk) begin
    stride     <= 15'((17'(dims.width) * 17'd3 + 17'd3) & ~17'd3);
    data_size  <= 32'(stride) * 32'(dims.height);
    total_size <= data_size + 32'(HEADER_BYTES);
  end

  assign neg_height = 32'd0 - 32'(dims.height);
  assign r5 = head.pixel[15:11];
  assign g6 = head.pixel[10:5];
  assign b5 = head.pixel[4:0];

  always_comb begin
    pos_cur  = started ? pos : (head.header ? '0 : POS_W'(POS_BLUE));
    last_pos = POS_W'(POS_RED) + POS_W'(head.pad);
    is_last  = pos_cur == last_pos;
    if (32'(pos_cur) < HEADER_BYTES) begin
      next_byte = hdr_byte(pos_cur, total_size, 32'(dims.width), neg_height, data_size);
    end else if (32'(pos_cur) == POS_BLUE) begin
      next_byte = {b5, b5[4:2]};
    end else if (32'(pos_cur) == POS_GREEN) begin
      next_byte = {g6, g6[5:4]};
    end else if (32'(pos_cur) == POS_RED) begin
      next_byte = {r5, r5[4:2]};
    end else begin
      next_byte = 8'd0;
    end
  end

  assign load = head_valid && (!ov || byte_out.ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pos     <= '0;
      ov      <= 1'b0;
    end else begin
      if (load) begin
        ov <= 1'b1;
        if (is_last) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          pos     <= pos_cur + POS_W'(1);
        end
      end else if (byte_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= next_byte;
      orl   <= is_last;
      ofl   <= is_last && head.frame_end;
    end
  end

  assign byte_out.valid      = ov;
  assign byte_out.out_byte   = obyte;
  assign byte_out.run_last   = orl;
  assign byte_out.frame_last = ofl;

endmodule

// ----- rtl/rgb565_to_bmp24_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_bmp24_stream
// rgb565 pixel stream to top-down 24-bit bmp file byte stream
// ----------------------------------------------------------------------------
// Pixels arrive one per transfer in raster order and leave as a byte stream,
// one byte per transfer: the 54-byte bmp header ahead of each frame's first
// pixel, then blue, green, red for every pixel, then zero padding at each row
// end up to a 4-byte stride. run_last marks each pixel's last byte, padding
// included, and frame_last the last byte of the file. The byte channel is
// the bottleneck: a pixel makes 3 bytes, plus 0 to 3 padding bytes at a row
// end and 54 header bytes at a frame start; pixel input is taken while
// earlier bytes go out, through a two-entry queue, so the byte output never
// idles while work is waiting. Width and height are written over apb (reg 0
// at address 0, reg 1 at address 4); the user must write them only while the
// block is idle, which it does not enforce. Of the low 13 bits kept, 0 acts
// as 1 and values above MAX_DIMENSION clamp; size fields lag a write.
module rgb565_to_bmp24_stream #(
  parameter int MAX_DIMENSION = rgb2bmp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  rgb2bmp_pix_if.sink                    pix_in,
  rgb2bmp_byte_if.source                 byte_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgb2bmp_pkg::APB_AW-1:0] paddr,
  input  logic [rgb2bmp_pkg::APB_DW-1:0] pwdata,
  output logic [rgb2bmp_pkg::APB_DW-1:0] prdata,
  output logic                           pready
);
  import rgb2bmp_pkg::*;

  // column and row counters just wide enough for the largest frame
  localparam int CW = $clog2(MAX_DIMENSION);

  dims_t  dims;
  entry_t push_data;
  logic   push_valid;
  logic   push_ready;
  entry_t head;
  logic   head_valid;
  logic   pop;

  // register file, clamped dimensions out
  rgb2bmp_cfg #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  // front: takes a pixel transfer and classifies it against the counters
  rgb2bmp_front #(
    .CW(CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .dims       (dims),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decoupling queue, pixel input stalls only when it is full
  rgb2bmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: walks header, pixel and padding bytes of the head entry
  rgb2bmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .byte_out   (byte_out)
  );

endmodule

// ----- rtl/rgb2bmp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2bmp_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
module rgb2bmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_last
);

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] pend;
  logic       expect_b;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // pixels taken whose bytes are not all out yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      expect_b <= 1'b1;
    end else begin
      case ({in_xfer, out_xfer && run_last})
        2'b10:   pend <= pend + 3'd1;
        2'b01:   pend <= pend - 3'd1;
        default: pend <= pend;
      endcase
      if (out_xfer) begin
        expect_b <= frame_last;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(frame_last))
    else $error("stalled output byte changed");

  a_frame_last_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame end without pixel end");

  a_file_start: assert property (@(posedge clk) disable iff (rst)
    out_xfer && expect_b |-> out_byte == 8'h42 && !run_last)
    else $error("file does not start with header");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pend != 3'd0)
    else $error("byte with no pixel behind it");

endmodule

bind rgb565_to_bmp24_stream rgb2bmp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (byte_out.valid),
  .out_ready  (byte_out.ready),
  .out_byte   (byte_out.out_byte),
  .run_last   (byte_out.run_last),
  .frame_last (byte_out.frame_last)
);
